// ----- hw/rtl/rcq_pkg.sv -----
// Package for the rotating circular queue: field widths, default capacity,
// operation and error codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcq_pkg;

  // Field widths of the request and result channels
  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int AMT_W   = 8;
  localparam int COUNT_W = 7;
  localparam int ERR_W   = 2;

  // Default number of ring entries
  localparam int CAPACITY_DEF = 64;

  // Operation codes (code 3 is unused and leaves the queue alone)
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_ROTATE = 2'd2
  } op_t;

  // Error codes reported with each result
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcq_store.sv -----
// Ring value store: one write port and one registered read port.
// Depends on rcq_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module rcq_store
  import rcq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_idx,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [CAPACITY];

  // Write the pushed value at the tail slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Register the head read; hold the last data otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rotating_circular_queue.sv -----
// Top level of the rotating circular queue: sequencer, ring pointers and
// result register. Depends on rcq_pkg and rcq_store.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     operation, push_value, rotate_amount
//   out_     output     out_valid / out_ready   head_value, is_empty, element_count,
//                                               error_code
//
// Push, pop and unused codes go from request to result through execute, head
// read from the store's registered port, then result. Rotate by k steps the
// offset counter once per move, wrapping at the element count, then one shared
// ring adder moves the head.
// Reset (synchronous, rst_n low) empties the queue; the store is not cleared.
// in_ready is high only while idle; a result holds until out_ready takes it.
`timescale 1ns / 1ps
`default_nettype none

module rotating_circular_queue
  import rcq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic        [OP_W-1:0]    in_operation,
  input  wire logic signed [DATA_W-1:0]  in_push_value,
  input  wire logic        [AMT_W-1:0]   in_rotate_amount,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed      [DATA_W-1:0]  out_head_value,
  output logic                           out_is_empty,
  output logic             [COUNT_W-1:0] out_element_count,
  output logic             [ERR_W-1:0]   out_error_code
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_READ = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AMT_W-1:0]   amt_r, amt_nxt;
  logic [CNT_W-1:0]   off_r, off_nxt;
  err_t               err_r, err_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  logic [CNT_W-1:0]   add_b;
  logic [SUM_W-1:0]   ring_sum;
  logic [IDX_W-1:0]   ring_idx;
  logic [CNT_W-1:0]   off_step;
  logic               wr_en;
  logic [DATA_W-1:0]  rd_data;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign accept = in_valid && in_ready;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // Shared ring adder: head plus count (tail), plus one (pop) or plus offset
  always_comb begin
    if (state_r == ST_ROT) begin
      add_b = off_r;
    end else if (in_operation == OP_POP) begin
      add_b = CNT_W'(1);
    end else begin
      add_b = count_r;
    end
  end

  assign ring_sum = SUM_W'(head_r) + SUM_W'(add_b);
  assign ring_idx = (ring_sum >= SUM_W'(CAPACITY)) ?
                    IDX_W'(ring_sum - SUM_W'(CAPACITY)) : IDX_W'(ring_sum);

  // Advance the rotate offset, wrapping at the element count
  assign off_step = off_r + CNT_W'(1);

  assign wr_en = accept && (in_operation == OP_PUSH) && !full;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    amt_nxt   = amt_r;
    off_nxt   = off_r;
    err_nxt   = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
          err_nxt   = ERR_OK;
          priority case (in_operation)
            OP_PUSH: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                err_nxt = ERR_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                head_nxt  = (count_r == CNT_W'(1)) ? '0 : ring_idx;
              end
            end
            OP_ROTATE: begin
              if (empty) begin
                err_nxt = ERR_EMPTY;
              end else begin
                state_nxt = ST_ROT;
                amt_nxt   = in_rotate_amount;
                off_nxt   = '0;
              end
            end
            default: begin
              // unused code: report state unchanged
            end
          endcase
        end
      end
      ST_ROT: begin
        if (amt_r == '0) begin
          head_nxt  = ring_idx;
          state_nxt = ST_READ;
        end else begin
          amt_nxt = amt_r - AMT_W'(1);
          off_nxt = (off_step == count_r) ? '0 : off_step;
        end
      end
      ST_READ: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers: no reset needed
  always_ff @(posedge clk) begin
    amt_r <= amt_nxt;
    off_r <= off_nxt;
    err_r <= err_nxt;
  end

  rcq_store #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (ring_idx),
    .wr_data (in_push_value),
    .rd_en   (state_r == ST_READ),
    .rd_idx  (head_r),
    .rd_data (rd_data)
  );

  // Drive the result from held registers
  assign count_ext         = {{COUNT_W{1'b0}}, count_r};
  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_head_value    = empty ? '0 : $signed(rd_data);
  assign out_is_empty      = empty;
  assign out_element_count = count_ext[COUNT_W-1:0];
  assign out_error_code    = err_r;

endmodule

`default_nettype wire
